### sv/uv_grid_accumulator_top_defines.svh
// Assertion macros used by the checker
`ifndef UV_GRID_ACCUMULATOR_TOP_DEFINES_SVH
`define UV_GRID_ACCUMULATOR_TOP_DEFINES_SVH
// Property must hold at every clock edge outside reset
`define UVG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked during reset as well
`define UVG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

### sv/uvg_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uvg_pkg
// Commands, register indexes, saturation limits and the decoded request type.
// ---------------------------------------------------------------------------
package uvg_pkg;
  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_NORM  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  localparam logic [1:0] REG_SCALE_U = 2'd0;
  localparam logic [1:0] REG_SCALE_V = 2'd1;
  localparam logic [1:0] REG_IMAGE_MODE = 2'd2;
  localparam logic [1:0] REG_INVERT = 2'd3;
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [31:0] SCALE_RESET = 32'd536871;

  localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;

  // Decoded request passed from the front end to the back end
  typedef struct packed {
    cmd_t               cmd;
    logic               go;
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic signed [63:0] px0;   // rounded products, first point
    logic signed [63:0] py0;
    logic signed [63:0] px1;   // mirrored point
    logic signed [63:0] py1;
    logic [6:0]         cell_x;
    logic [6:0]         cell_y;
  } req_t;

  // 48-bit signed saturating add of a sign-extended 33-bit value
  function automatic logic signed [47:0] sat_add(input logic signed [47:0] a,
                                                 input logic signed [32:0] b);
    logic signed [48:0] s;
    begin
      s = {a[47], a} + {{16{b[32]}}, b};
      if (s[48] != s[47]) sat_add = s[48] ? MIN48 : MAX48;
      else sat_add = s[47:0];
    end
  endfunction
endpackage

### sv/uvg_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uvg_if
// Valid/ready channel with a generic payload type.
// ---------------------------------------------------------------------------
interface uvg_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/uvg_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uvg_ram
// Single-port RAM with registered read data.
// ---------------------------------------------------------------------------
module uvg_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

### sv/uvg_divider.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uvg_divider
// Restoring signed divider, one quotient bit a cycle, truncates toward zero.
// ---------------------------------------------------------------------------
module uvg_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [47:0] num,
  input  logic [31:0]        den,
  output logic               done,
  output logic signed [47:0] quo
);
  logic [47:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, neg_r, neg_nxt, done_r, done_nxt;
  logic [31:0] den_r, den_nxt;
  logic [32:0] trial;

  assign trial = {rem_r[31:0], q_r[47]};
  assign done  = done_r;
  assign quo   = neg_r ? -$signed(q_r) : $signed(q_r);

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    neg_nxt = neg_r; den_nxt = den_r; done_nxt = 1'b0;
    if (start) begin
      q_nxt = num[47] ? 48'(-num) : num;
      neg_nxt = num[47]; den_nxt = den; rem_nxt = '0;
      cnt_nxt = 6'd48; busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift one numerator bit into the remainder, subtract if it fits
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[46:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[46:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; neg_r <= neg_nxt; den_r <= den_nxt;
  end
endmodule

### sv/uvg_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uvg_front
// Takes input requests, decides gridding and forms the rounded positions
// over two pipeline steps (32x32 products then rounding), into a request queue.
// ---------------------------------------------------------------------------
module uvg_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         in_cmd,
  input  logic signed [31:0] in_u,
  input  logic signed [31:0] in_v,
  input  logic signed [31:0] in_re,
  input  logic signed [31:0] in_im,
  input  logic               in_flagged,
  input  logic               in_finite,
  input  logic [6:0]         in_cell_x,
  input  logic [6:0]         in_cell_y,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        scale_u,
  input  logic [31:0]        scale_v,
  input  logic               image_mode,
  input  logic               invert_flags,
  output uvg_pkg::req_t      q_data,
  output logic               q_valid,
  input  logic               q_pop
);
  localparam logic signed [63:0] HALF = 64'sh8000_0000;

  // Stage 1: products
  logic                s1_v_r;
  logic                s1_go_r;
  uvg_pkg::cmd_t       s1_cmd_r;
  logic signed [31:0]  s1_re_r, s1_im_r;
  logic signed [63:0]  s1_pu_r, s1_pv_r;
  logic [6:0]          s1_x_r, s1_y_r;
  logic                go;
  logic                accept;

  // Two-entry queue
  uvg_pkg::req_t q_r [2];
  logic [1:0]    cnt_r, cnt_nxt;
  logic          wr_ptr_r, rd_ptr_r;
  logic          push;
  uvg_pkg::req_t push_data;

  // One request in flight in stage 1 plus queue must not overflow
  assign in_ready = (cnt_r == 2'd0) || (cnt_r == 2'd1 && !s1_v_r);
  assign accept = in_valid && in_ready;

  always_comb begin
    if (image_mode) go = in_flagged ^ invert_flags;
    else go = !in_flagged && in_finite;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else s1_v_r <= accept;
    if (accept) begin
      s1_cmd_r <= uvg_pkg::cmd_t'(in_cmd);
      s1_go_r  <= go;
      s1_re_r  <= image_mode ? 32'sd1 : in_re;
      s1_im_r  <= image_mode ? 32'sd0 : in_im;
      s1_pu_r  <= in_u * $signed({1'b0, scale_u});
      s1_pv_r  <= in_v * $signed({1'b0, scale_v});
      s1_x_r   <= in_cell_x;
      s1_y_r   <= in_cell_y;
    end
  end

  // Stage 2: rounding offsets; negated product is exact for the mirror point
  always_comb begin
    push = s1_v_r;
    push_data.cmd    = s1_cmd_r;
    push_data.go     = s1_go_r;
    push_data.re     = s1_re_r;
    push_data.im     = s1_im_r;
    push_data.px0    = s1_pu_r + HALF;
    push_data.py0    = s1_pv_r + HALF;
    push_data.px1    = HALF - s1_pu_r;
    push_data.py1    = HALF - s1_pv_r;
    push_data.cell_x = s1_x_r;
    push_data.cell_y = s1_y_r;
  end

  assign q_valid = cnt_r != 2'd0;
  assign q_data  = q_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) cnt_nxt = cnt_r + 2'd1;
    else if (!push && q_pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; wr_ptr_r <= 1'b0; rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (q_pop) rd_ptr_r <= !rd_ptr_r;
    end
    if (push) q_r[wr_ptr_r] <= push_data;
  end
endmodule

### sv/uvg_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uvg_back
// Grid memories and the command sequencer: up to two read-modify-writes per
// sample, cell read, normalise sweep and clear sweep, plus the result register.
// ---------------------------------------------------------------------------
module uvg_back #(
  parameter int unsigned GRID_W = 128,
  parameter int unsigned GRID_H = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  uvg_pkg::req_t      q_data,
  input  logic               q_valid,
  output logic               q_pop,
  output logic signed [47:0] out_re,
  output logic signed [47:0] out_im,
  output logic [31:0]        out_weight,
  output logic               out_clipped,
  output logic               out_first_clip,
  output logic               out_valid,
  input  logic               out_ready
);
  localparam int unsigned CELLS = GRID_W * GRID_H;
  localparam int unsigned AW = $clog2(CELLS);
  localparam int unsigned XW = $clog2(GRID_W);
  localparam int unsigned YW = $clog2(GRID_H);
  localparam logic signed [33:0] HALF_W = 34'(GRID_W / 2);
  localparam logic signed [33:0] HALF_H = 34'(GRID_H / 2);
  localparam logic [AW:0] LAST = (AW+1)'(CELLS - 1);
  localparam logic [AW:0] IDX_ONE = (AW+1)'(1);

  typedef enum logic [8:0] {
    S_INIT  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_PT_RD = 9'b000000100,
    S_PT_WR = 9'b000001000,
    S_RD    = 9'b000010000,
    S_N_RD  = 9'b000100000,
    S_N_DV  = 9'b001000000,
    S_N_WR  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [AW:0]  idx_r, idx_nxt;      // sweep counter, one bit wider than the address
  logic         pt_r, pt_nxt;        // which point of a sample
  logic         clip_seen_r, clip_seen_nxt;
  logic         clip_r, clip_nxt;
  logic         read_ok_r, read_ok_nxt;
  logic         div_im_r, div_im_nxt;
  logic signed [47:0] nre_r, nre_nxt;

  logic signed [47:0] o_re_r, o_re_nxt, o_im_r, o_im_nxt;
  logic [31:0]        o_w_r, o_w_nxt;
  logic               o_clip_r, o_clip_nxt, o_first_r, o_first_nxt, o_v_r, o_v_nxt;

  // memory ports
  logic          we;
  logic [AW-1:0] addr;
  logic [47:0]   wre, wim, rre, rim;
  logic [31:0]   ww, rw;
  logic [AW-1:0] pt_addr_r, pt_addr_nxt;

  // divider
  logic               div_start, div_done;
  logic signed [47:0] div_num, div_quo;

  // cell position of the current point
  logic signed [63:0] px, py;
  logic signed [33:0] cx, cy;
  logic               pt_in;
  logic [AW-1:0]      pt_addr;
  logic signed [32:0] add_im;

  uvg_ram #(.WIDTH(48), .DEPTH(CELLS)) u_ram_re (
    .clk(clk), .we(we), .addr(addr), .wdata(wre), .rdata(rre));
  uvg_ram #(.WIDTH(48), .DEPTH(CELLS)) u_ram_im (
    .clk(clk), .we(we), .addr(addr), .wdata(wim), .rdata(rim));
  uvg_ram #(.WIDTH(32), .DEPTH(CELLS)) u_ram_w (
    .clk(clk), .we(we), .addr(addr), .wdata(ww), .rdata(rw));

  uvg_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
    .den(rw), .done(div_done), .quo(div_quo));

  // floor by 2^32 is the arithmetic top word
  always_comb begin
    px = pt_r ? q_data.px1 : q_data.px0;
    py = pt_r ? q_data.py1 : q_data.py0;
    cx = $signed({px[63], px[63:32]}) + HALF_W;
    cy = $signed({py[63], py[63:32]}) + HALF_H;
    pt_in = !cx[33] && (cx < $signed(34'(GRID_W))) &&
            !cy[33] && (cy < $signed(34'(GRID_H)));
    pt_addr = AW'(cy[YW-1:0]) * AW'(GRID_W) + AW'(cx[XW-1:0]);
    add_im = pt_r ? -$signed({q_data.im[31], q_data.im})
                  : $signed({q_data.im[31], q_data.im});
  end

  assign out_re = o_re_r;
  assign out_im = o_im_r;
  assign out_weight = o_w_r;
  assign out_clipped = o_clip_r;
  assign out_first_clip = o_first_r;
  assign out_valid = o_v_r;
  // the imaginary division starts in the cycle that selects it
  assign div_num = div_im_nxt ? rim : rre;

  always_comb begin
    state_nxt = state_r; idx_nxt = idx_r; pt_nxt = pt_r;
    clip_seen_nxt = clip_seen_r; clip_nxt = clip_r; read_ok_nxt = read_ok_r;
    div_im_nxt = div_im_r; nre_nxt = nre_r; pt_addr_nxt = pt_addr_r;
    o_re_nxt = o_re_r; o_im_nxt = o_im_r; o_w_nxt = o_w_r;
    o_clip_nxt = o_clip_r; o_first_nxt = o_first_r; o_v_nxt = o_v_r;
    we = 1'b0; addr = idx_r[AW-1:0]; wre = '0; wim = '0; ww = '0;
    q_pop = 1'b0; div_start = 1'b0;
    if (out_ready) o_v_nxt = 1'b0;
    case (state_r)
      S_INIT: begin
        // clearing sweep after reset or a clear command
        we = 1'b1;
        idx_nxt = idx_r + IDX_ONE;
        if (idx_r == LAST) begin
          state_nxt = S_IDLE; idx_nxt = '0;
        end
      end
      S_IDLE: begin
        if (q_valid && (!o_v_r || out_ready)) begin
          o_re_nxt = '0; o_im_nxt = '0; o_w_nxt = '0;
          o_clip_nxt = 1'b0; o_first_nxt = 1'b0;
          idx_nxt = '0; pt_nxt = 1'b0; clip_nxt = 1'b0;
          case (q_data.cmd)
            uvg_pkg::CMD_ADD: begin
              if (q_data.go) state_nxt = S_PT_RD;
              else state_nxt = S_OUT;
            end
            uvg_pkg::CMD_READ: begin
              read_ok_nxt = (32'(q_data.cell_x) < GRID_W) &&
                            (32'(q_data.cell_y) < GRID_H);
              addr = AW'(q_data.cell_y) * AW'(GRID_W) + AW'(q_data.cell_x);
              state_nxt = S_RD;
            end
            uvg_pkg::CMD_NORM: state_nxt = S_N_RD;
            uvg_pkg::CMD_CLEAR: begin
              clip_seen_nxt = 1'b0; state_nxt = S_INIT;
              q_pop = 1'b1; o_v_nxt = 1'b1;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_PT_RD: begin
        addr = pt_addr;
        pt_addr_nxt = pt_addr;
        if (pt_in) state_nxt = S_PT_WR;
        else begin
          clip_nxt = 1'b1;
          if (pt_r) state_nxt = S_OUT;
          else pt_nxt = 1'b1;
        end
      end
      S_PT_WR: begin
        addr = pt_addr_r; we = 1'b1;
        wre = uvg_pkg::sat_add(rre, {q_data.re[31], q_data.re});
        wim = uvg_pkg::sat_add(rim, add_im);
        ww = (rw == 32'hFFFF_FFFF) ? rw : rw + 32'd1;
        if (pt_r) state_nxt = S_OUT;
        else begin
          pt_nxt = 1'b1; state_nxt = S_PT_RD;
        end
      end
      S_RD: begin
        if (read_ok_r) begin
          o_re_nxt = rre; o_im_nxt = rim; o_w_nxt = rw;
        end
        q_pop = 1'b1; o_v_nxt = 1'b1; state_nxt = S_IDLE;
      end
      S_N_RD: begin
        // address issued; data valid next cycle
        state_nxt = S_N_DV; div_im_nxt = 1'b0;
      end
      S_N_DV: begin
        if (rw == 32'd0) begin
          idx_nxt = idx_r + IDX_ONE;
          if (idx_r == LAST) state_nxt = S_OUT;
          else state_nxt = S_N_RD;
        end else begin
          div_start = 1'b1; state_nxt = S_N_WR;
        end
      end
      S_N_WR: begin
        if (div_done) begin
          if (!div_im_r) begin
            nre_nxt = div_quo; div_im_nxt = 1'b1; div_start = 1'b1;
          end else begin
            we = 1'b1; wre = nre_r; wim = div_quo; ww = 32'd1;
            idx_nxt = idx_r + IDX_ONE;
            if (idx_r == LAST) state_nxt = S_OUT;
            else state_nxt = S_N_RD;
          end
        end
      end
      S_OUT: begin
        if (clip_r) begin
          o_clip_nxt = 1'b1; o_first_nxt = !clip_seen_r; clip_seen_nxt = 1'b1;
        end
        q_pop = 1'b1; o_v_nxt = 1'b1; state_nxt = S_IDLE; idx_nxt = '0;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT; idx_r <= '0; clip_seen_r <= 1'b0; o_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt; idx_r <= idx_nxt; clip_seen_r <= clip_seen_nxt;
      o_v_r <= o_v_nxt;
    end
    pt_r <= pt_nxt; clip_r <= clip_nxt; read_ok_r <= read_ok_nxt;
    div_im_r <= div_im_nxt; nre_r <= nre_nxt; pt_addr_r <= pt_addr_nxt;
    o_re_r <= o_re_nxt; o_im_r <= o_im_nxt; o_w_r <= o_w_nxt;
    o_clip_r <= o_clip_nxt; o_first_r <= o_first_nxt;
  end
endmodule

### sv/uv_grid_accumulator_top.sv
`timescale 1ns / 1ps
// Adding a sample passes the two front stages and up to two read-modify-writes;
//   the back end dispatches a sample, runs its read-modify-writes and gives the
//   result before it takes the next request; reading a cell is a single read.
// Normalise walks all GRID_W*GRID_H cells; a filled cell takes two 48-step
//   divisions, an empty cell none; clear walks all GRID_W*GRID_H cells.
// Reset (rst_n low, synchronous) starts a clearing pass over all GRID_W*GRID_H
//   cells through the single memory port; up to two requests queue meanwhile.
// ---------------------------------------------------------------------------
// uv_grid_accumulator_top
// Nearest-neighbour UV gridding accumulator with decoupled front and back.
// ---------------------------------------------------------------------------
module uv_grid_accumulator_top #(
  parameter int unsigned GRID_W = 128,
  parameter int unsigned GRID_H = 128
) (
  input logic clk,
  input logic rst_n,
  uvg_if.sink   in_ch,
  uvg_if.sink   cfg_ch,
  uvg_if.source out_ch
);
  logic [31:0] scale_u_r, scale_v_r;
  logic        image_mode_r, invert_r;
  uvg_pkg::req_t q_data;
  logic q_valid, q_pop;

  // configuration registers, always ready
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_u_r <= uvg_pkg::SCALE_RESET; scale_v_r <= uvg_pkg::SCALE_RESET;
      image_mode_r <= 1'b0; invert_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.data.idx == 8'(uvg_pkg::REG_SCALE_U)) scale_u_r <= cfg_ch.data.wdata;
      if (cfg_ch.data.idx == 8'(uvg_pkg::REG_SCALE_V)) scale_v_r <= cfg_ch.data.wdata;
      if (cfg_ch.data.idx == 8'(uvg_pkg::REG_IMAGE_MODE)) image_mode_r <= cfg_ch.data.wdata[0];
      if (cfg_ch.data.idx == 8'(uvg_pkg::REG_INVERT)) invert_r <= cfg_ch.data.wdata[0];
    end
  end

  uvg_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_cmd(in_ch.data.cmd), .in_u(in_ch.data.u_wl), .in_v(in_ch.data.v_wl),
    .in_re(in_ch.data.re_in), .in_im(in_ch.data.im_in),
    .in_flagged(in_ch.data.flagged), .in_finite(in_ch.data.finite),
    .in_cell_x(in_ch.data.cell_x), .in_cell_y(in_ch.data.cell_y),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .scale_u(scale_u_r), .scale_v(scale_v_r),
    .image_mode(image_mode_r), .invert_flags(invert_r),
    .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop));

  uvg_back #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_back (
    .clk(clk), .rst_n(rst_n), .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop),
    .out_re(out_ch.data.re_out), .out_im(out_ch.data.im_out),
    .out_weight(out_ch.data.weight_out), .out_clipped(out_ch.data.clipped),
    .out_first_clip(out_ch.data.first_clip),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready));
endmodule

### sv/uvg_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uvg_checker
// Port-level checks on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "uv_grid_accumulator_top_defines.svh"
module uvg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        clipped,
  input logic        first_clip,
  input logic [31:0] weight_out
);
  // first_clip only ever with clipped
  `UVG_ASSERT(a_first_needs_clip, clk, rst_n, out_valid |-> (!first_clip || clipped), "first_clip without clipped")
  // a clipped add never carries read data
  `UVG_ASSERT(a_clip_no_weight, clk, rst_n, (out_valid && clipped) |-> (weight_out == 32'd0), "clip with weight")
  // a stalled result holds
  `UVG_ASSERT(a_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid, "result dropped")
  // no result straight out of reset
  `UVG_ASSERT_ALWAYS(a_reset, clk, !rst_n |=> !out_valid, "result after reset")
endmodule

bind uv_grid_accumulator_top uvg_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .clipped(out_ch.data.clipped), .first_clip(out_ch.data.first_clip),
  .weight_out(out_ch.data.weight_out));
